[hw/rtl/wsi_pkg.sv]
// Package with types and constants shared by the waypoint setpoint interpolator.
package wsi_pkg;
    localparam int WSI_WAYPOINT_COUNT = 8;
    localparam logic [9:0] WSI_PERIOD_RESET = 10'd10;
    localparam logic signed [31:0] WSI_Q_HUNDRED = 32'sd6553600;
    localparam logic [15:0] WSI_INIT_TIME = 16'd10000;
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic AXIS_PAN = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_TDIV  = 8'b0000_1000,
        ST_PDIV  = 8'b0001_0000,
        ST_SDIV  = 8'b0010_0000,
        ST_SDONE = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction
endpackage

[hw/rtl/waypoint_setpoint_interpolator.sv]
// Two-axis waypoint setpoint interpolator with a shared serial divider.
// An interpolating request passes through a multiply state; a segment end without scan
// answers from idle; a tilt request that starts new segments scans up to WAYPOINT_COUNT
// entries and, on a hit, runs three restoring divisions on one shared divider.
// Throughput: one transaction at a time; ready is low while a request is worked on.
// Reset (synchronous, active low) restores the default table and clears segments.
module waypoint_setpoint_interpolator #(
    parameter int WAYPOINT_COUNT = wsi_pkg::WSI_WAYPOINT_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [9:0]                      i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic                            i_axis,
    input  logic signed [31:0]              i_measured_pos,
    input  logic [2:0]                      i_wp_index,
    input  logic                            i_wp_active,
    input  logic signed [31:0]              i_wp_pan,
    input  logic signed [31:0]              i_wp_tilt,
    input  logic [15:0]                     i_wp_time_ms,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [31:0]              o_setpoint,
    output logic                            o_no_active_waypoint
);
    import wsi_pkg::*;

    localparam int IW = (WAYPOINT_COUNT > 1) ? $clog2(WAYPOINT_COUNT) : 1;

    logic [WAYPOINT_COUNT-1:0] r_active;
    logic signed [31:0] r_pan  [WAYPOINT_COUNT];
    logic signed [31:0] r_tilt [WAYPOINT_COUNT];
    logic [15:0]        r_time [WAYPOINT_COUNT];
    logic [IW-1:0]      r_next;
    logic signed [31:0] r_start [2];
    logic signed [31:0] r_end   [2];
    logic [15:0]        r_tick  [2];
    logic [15:0]        r_total [2];
    logic signed [31:0] r_step  [2];
    logic [9:0]         r_period;

    t_state             r_state;
    logic               r_axis;
    logic signed [31:0] r_meas;
    logic signed [63:0] r_prod;
    logic [IW-1:0]      r_ptr;
    logic [IW:0]        r_cnt;
    logic [IW-1:0]      r_hit;
    // Shared restoring divider: remainder, quotient/dividend, divisor, bit count.
    logic [32:0]        r_rem;
    logic [32:0]        r_quo;
    logic [15:0]        r_dvs;
    logic [5:0]         r_bits;
    logic               r_neg;
    logic               r_ovalid;
    logic signed [31:0] r_osp;
    logic               r_onone;

    logic        in_acc;
    logic        w_ok;
    logic [IW-1:0] w_widx;
    logic [33:0] w_trial;
    logic [32:0] w_span_mag;
    logic signed [32:0] w_span;
    logic [IW-1:0] w_ptr_inc;
    logic signed [33:0] w_sq;
    logic signed [48:0] w_mul;

    assign in_acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_setpoint = r_osp;
    assign o_no_active_waypoint = r_onone;
    assign w_ok = ({29'd0, i_wp_index} < 32'(WAYPOINT_COUNT));
    assign w_widx = IW'(i_wp_index);
    assign w_trial = {r_rem, r_quo[32]} - {18'd0, r_dvs};
    assign w_ptr_inc = (r_ptr == IW'(WAYPOINT_COUNT - 1)) ? '0 : r_ptr + 1'b1;
    assign w_sq = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_mul = r_step[i_axis] * $signed({1'b0, r_tick[i_axis]});

    always_comb begin
        // Span of the segment being set up: pan while in ST_TDIV (loaded for ST_PDIV), tilt otherwise.
        if (r_state == ST_TDIV) begin
            w_span = 33'(r_pan[r_hit]) - 33'(r_start[0]);
        end else begin
            w_span = 33'(r_tilt[r_hit]) - 33'(r_meas);
        end
        w_span_mag = w_span[32] ? 33'(-w_span) : 33'(w_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_period <= WSI_PERIOD_RESET;
            r_next   <= '0;
            for (int k = 0; k < WAYPOINT_COUNT; k++) begin
                r_active[k] <= (k < 2);
                r_pan[k]    <= (k == 1) ? WSI_Q_HUNDRED : '0;
                r_tilt[k]   <= (k == 1) ? WSI_Q_HUNDRED : '0;
                r_time[k]   <= (k < 2) ? WSI_INIT_TIME : '0;
            end
            for (int a = 0; a < 2; a++) begin
                r_start[a] <= '0;
                r_end[a]   <= '0;
                r_tick[a]  <= '0;
                r_total[a] <= '0;
                r_step[a]  <= '0;
            end
        end else begin
            if (i_cfg_we) r_period <= i_cfg_wdata;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_axis <= i_axis;
                        r_meas <= i_measured_pos;
                        if (i_opcode == OP_WRITE) begin
                            if (w_ok) begin
                                r_active[w_widx] <= i_wp_active;
                                r_pan[w_widx]    <= i_wp_pan;
                                r_tilt[w_widx]   <= i_wp_tilt;
                                r_time[w_widx]   <= i_wp_time_ms;
                            end
                        end else if (r_tick[i_axis] < r_total[i_axis]) begin
                            r_prod  <= 64'(w_mul);
                            r_state <= ST_MUL;
                        end else if (i_axis == AXIS_PAN) begin
                            r_start[0] <= i_measured_pos;
                            r_osp      <= r_end[0];
                            r_onone    <= 1'b0;
                            r_ovalid   <= 1'b1;
                        end else begin
                            r_ptr   <= r_next;
                            r_cnt   <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_MUL: begin
                    r_osp   <= sat32(64'(r_start[r_axis]) + r_prod);
                    r_tick[r_axis] <= r_tick[r_axis] + 16'd1;
                    r_onone <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (r_cnt == (IW+1)'(WAYPOINT_COUNT)) begin
                        r_start[1] <= r_meas;
                        for (int a = 0; a < 2; a++) begin
                            r_tick[a] <= '0;
                            r_total[a] <= '0;
                            r_step[a] <= '0;
                        end
                        r_osp <= r_meas;
                        r_onone <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (r_active[r_ptr]) begin
                        r_hit   <= r_ptr;
                        r_next  <= w_ptr_inc;
                        // Tick total = time / period, period zero read as one.
                        r_rem   <= '0;
                        r_quo   <= {r_time[r_ptr], 17'd0};
                        r_dvs   <= (r_period == '0) ? 16'd1 : {6'd0, r_period};
                        r_bits  <= 6'd16;
                        r_state <= ST_TDIV;
                    end else begin
                        r_ptr <= w_ptr_inc;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_TDIV, ST_PDIV, ST_SDIV: begin
                    if (r_bits != '0) begin
                        if (!w_trial[33]) r_rem <= w_trial[32:0];
                        else r_rem <= {r_rem[31:0], r_quo[32]};
                        r_quo  <= {r_quo[31:0], !w_trial[33]};
                        r_bits <= r_bits - 1'b1;
                    end else begin
                        r_state <= ST_SDONE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // Hand-over between divisions (kept apart for readability).
            if (r_state == ST_TDIV && r_bits == '0) begin
                r_total[0] <= r_quo[15:0];
                r_total[1] <= r_quo[15:0];
                r_dvs  <= r_quo[15:0];
                r_rem  <= '0;
                r_quo  <= w_span_mag;
                r_neg  <= w_span[32];
                r_bits <= 6'd33;
                r_start[1] <= r_meas;
                r_end[0] <= r_pan[r_hit];
                r_end[1] <= r_tilt[r_hit];
                r_tick[0] <= '0;
                r_tick[1] <= '0;
                r_state <= ST_PDIV;
            end else if (r_state == ST_PDIV && r_bits == '0) begin
                r_step[0] <= (r_dvs == '0) ? '0 : sat32(64'(w_sq));
                r_rem  <= '0;
                r_quo  <= w_span_mag;
                r_neg  <= w_span[32];
                r_bits <= 6'd33;
                r_state <= ST_SDIV;
            end else if (r_state == ST_SDIV && r_bits == '0) begin
                r_step[1] <= (r_dvs == '0) ? '0 : sat32(64'(w_sq));
                r_osp <= r_start[1];
                r_onone <= 1'b0;
                r_ovalid <= 1'b1;
                r_state <= ST_IDLE;
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_none_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_active_waypoint) |-> (r_axis == AXIS_TILT))
        else $error("no-active flag on pan");
`endif
endmodule

[bench/tb_top.sv]
// Self-checking testbench for the two-axis waypoint setpoint interpolator.
`timescale 1ns / 1ps

class setpoint_scoreboard;
    bit               act[8];
    logic signed [31:0] tgt_pan[8];
    logic signed [31:0] tgt_tilt[8];
    logic [15:0]      dur_ms[8];
    logic [2:0]       scan_from;
    logic signed [31:0] s_start[2];
    logic signed [31:0] s_end[2];
    logic [15:0]      s_tick[2];
    logic [15:0]      s_total[2];
    logic signed [31:0] s_step[2];
    logic [9:0]       period;
    logic signed [31:0] exp_setpoint[$];
    bit               exp_none[$];
    int               errors;

    function new();
        int i;
        for (i = 0; i < 8; i++) begin
            act[i] = (i < 2);
            tgt_pan[i] = (i == 1) ? wsi_pkg::WSI_Q_HUNDRED : 0;
            tgt_tilt[i] = (i == 1) ? wsi_pkg::WSI_Q_HUNDRED : 0;
            dur_ms[i] = (i < 2) ? wsi_pkg::WSI_INIT_TIME : 16'd0;
        end
        scan_from = 0;
        for (i = 0; i < 2; i++) begin
            s_start[i] = 0; s_end[i] = 0; s_tick[i] = 0; s_total[i] = 0; s_step[i] = 0;
        end
        period = wsi_pkg::WSI_PERIOD_RESET;
        errors = 0;
    endfunction

    static function logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function void start_axis(int ax, logic signed [31:0] from, logic signed [31:0] to,
                             logic [15:0] total);
        logic signed [63:0] span;
        span = 64'(to) - 64'(from);
        s_start[ax] = from;
        s_end[ax] = to;
        s_tick[ax] = 0;
        s_total[ax] = total;
        s_step[ax] = (total == 0) ? 32'sd0 : clip32(span / $signed({48'd0, total}));
    endfunction

    function void note_input(bit op, bit ax, logic signed [31:0] meas, logic [2:0] idx,
                             bit wact, logic signed [31:0] wpan, logic signed [31:0] wtilt,
                             logic [15:0] wtime);
        logic signed [31:0] sp;
        logic [9:0] per;
        logic [2:0] e;
        bit none, found;
        int k;
        if (op == wsi_pkg::OP_WRITE) begin
            act[idx] = wact; tgt_pan[idx] = wpan; tgt_tilt[idx] = wtilt; dur_ms[idx] = wtime;
            return;
        end
        none = 0;
        if (s_tick[ax] >= s_total[ax]) begin
            if (ax == wsi_pkg::AXIS_TILT) begin
                found = 0;
                for (k = 0; k < 8 && !found; k++) begin
                    e = scan_from + 3'(k);
                    if (act[e]) begin
                        found = 1;
                        per = (period == 0) ? 10'd1 : period;
                        scan_from = e + 3'd1;
                        start_axis(0, s_start[0], tgt_pan[e], 16'(dur_ms[e] / per));
                        start_axis(1, meas, tgt_tilt[e], 16'(dur_ms[e] / per));
                    end
                end
                if (!found) begin
                    none = 1;
                    start_axis(0, s_start[0], s_end[0], 0);
                    start_axis(1, meas, s_end[1], 0);
                end
                sp = s_start[1];
            end else begin
                s_start[0] = meas;
                sp = s_end[0];
            end
        end else begin
            sp = clip32(64'(s_start[ax]) + 64'(s_step[ax]) * $signed({48'd0, s_tick[ax]}));
            s_tick[ax] = s_tick[ax] + 16'd1;
        end
        exp_setpoint.push_back(sp);
        exp_none.push_back(none);
    endfunction

    function void check_result(logic signed [31:0] sp, bit none);
        if (exp_setpoint.size() == 0) begin
            $display("%0t: unexpected result setpoint %h", $time, sp);
            errors++;
            return;
        end
        if (sp !== exp_setpoint[0]) begin
            $display("%0t: setpoint expected %h actual %h", $time, exp_setpoint[0], sp);
            errors++;
        end
        if (none !== exp_none[0]) begin
            $display("%0t: no_active_waypoint expected %b actual %b", $time, exp_none[0], none);
            errors++;
        end
        void'(exp_setpoint.pop_front());
        void'(exp_none.pop_front());
    endfunction
endclass

module tb_top;
    import wsi_pkg::*;

    logic i_clk, i_rst_n, i_cfg_we, i_valid, o_ready, i_opcode, i_axis;
    logic [9:0] i_cfg_wdata;
    logic signed [31:0] i_measured_pos, i_wp_pan, i_wp_tilt, o_setpoint;
    logic [2:0] i_wp_index;
    logic i_wp_active, o_valid, i_ready, o_no_active_waypoint;
    logic [15:0] i_wp_time_ms;

    setpoint_scoreboard sb;
    bit busy_free;      // when set, neither side idles
    int hold_off;       // receiver holds ready low while this is nonzero

    waypoint_setpoint_interpolator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_opcode(i_opcode), .i_axis(i_axis),
        .i_measured_pos(i_measured_pos), .i_wp_index(i_wp_index),
        .i_wp_active(i_wp_active), .i_wp_pan(i_wp_pan), .i_wp_tilt(i_wp_tilt),
        .i_wp_time_ms(i_wp_time_ms), .o_valid(o_valid), .i_ready(i_ready),
        .o_setpoint(o_setpoint), .o_no_active_waypoint(o_no_active_waypoint)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random back-pressure, with an optional long hold-off.
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                i_ready <= 0;
                hold_off--;
            end else begin
                i_ready <= busy_free || ($urandom_range(99) >= 33);
            end
            if (o_valid && i_ready && i_rst_n)
                sb.check_result(o_setpoint, o_no_active_waypoint);
        end
    end

    // Valid stays high after an acceptance only when the next transaction follows at once.
    task automatic send(bit op, bit ax, logic signed [31:0] meas, logic [2:0] idx, bit act,
                        logic signed [31:0] pan, logic signed [31:0] tilt, logic [15:0] tm);
        while (!busy_free && $urandom_range(99) < 33) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_opcode <= op; i_axis <= ax; i_measured_pos <= meas;
        i_wp_index <= idx; i_wp_active <= act; i_wp_pan <= pan; i_wp_tilt <= tilt;
        i_wp_time_ms <= tm;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        sb.note_input(op, ax, meas, idx, act, pan, tilt, tm);
    endtask

    task automatic request(bit ax, logic signed [31:0] meas);
        send(OP_REQUEST, ax, meas, 3'($urandom), 1'($urandom), 32'($urandom),
             32'($urandom), 16'($urandom));
    endtask

    task automatic write_entry(logic [2:0] idx, bit act, logic signed [31:0] pan,
                               logic signed [31:0] tilt, logic [15:0] tm);
        send(OP_WRITE, 1'($urandom), 32'($urandom), idx, act, pan, tilt, tm);
    endtask

    task automatic set_period(logic [9:0] p);
        i_valid <= 0;
        while (sb.exp_setpoint.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.period = p;
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF ^ 32'($urandom_range(1));
            1: return 32'sh8000_0000 | 32'($urandom_range(1));
            default: return $urandom;
        endcase
    endfunction

    // One random phase: mostly requests that walk the segments, with occasional table writes.
    task automatic random_phase(int n, int max_time);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 12)
                write_entry(3'($urandom), $urandom_range(99) < 60, rand_pos(), rand_pos(),
                            16'($urandom_range(max_time)));
            else
                request(1'($urandom_range(1)), rand_pos());
        end
    endtask

    initial begin
        int i, timer;
        sb = new();
        busy_free = 0; hold_off = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0; i_valid = 0; i_opcode = 0; i_axis = 0;
        i_measured_pos = 0; i_wp_index = 0; i_wp_active = 0; i_wp_pan = 0; i_wp_tilt = 0;
        i_wp_time_ms = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: default table, extreme values, zero durations and an empty ring.
        request(AXIS_PAN, 32'sh0001_0000);
        request(AXIS_TILT, 32'sh0002_0000);
        request(AXIS_TILT, 32'sh8000_0000);
        request(AXIS_PAN, 32'sh7FFF_FFFF);
        write_entry(3'd2, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
        write_entry(3'd3, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0);
        for (i = 0; i < 6; i++) request(i[0], i[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        for (i = 0; i < 8; i++) write_entry(i[2:0], 1'b0, 32'sd0, 32'sd0, 16'd0);
        request(AXIS_TILT, 32'sh1234_5678);
        request(AXIS_TILT, 32'shFFFF_FFFF);
        request(AXIS_PAN, 32'sd0);
        write_entry(3'd7, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd40);

        set_period(10'd1);
        random_phase(300, 40);
        set_period(10'd0);
        random_phase(250, 30);
        set_period(10'h3FF);
        random_phase(250, 65535);
        set_period(10'd7);
        busy_free = 1;
        random_phase(200, 100);
        busy_free = 0;
        // Long receiver hold-off while requests keep coming.
        fork
            hold_off = 400;
            random_phase(50, 60);
        join
        set_period(10'd3);
        random_phase(400, 80);
        i_valid <= 0;

        timer = 0;
        while (sb.exp_setpoint.size() != 0 && timer < 100000) begin
            @(posedge i_clk);
            timer++;
        end
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_setpoint.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
